// ----- rtl/dssd_pkg.sv -----
// Shared types, constants and helper functions of the delta sample stream decoder.
package dssd_pkg;

	localparam int SampleW   = 16;
	localparam int HighW     = 5;
	localparam int AbsW      = 13;
	localparam int Delta7W   = 7;
	localparam int Delta3W   = 3;

	localparam logic signed [SampleW-1:0] RangeLow  = -16'sd2000;
	localparam logic signed [SampleW-1:0] RangeHigh = 16'sd2000;

	// Range status codes.
	localparam logic [1:0] RANGE_IN    = 2'd0;
	localparam logic [1:0] RANGE_BELOW = 2'd1;
	localparam logic [1:0] RANGE_ABOVE = 2'd2;

	// Byte class prefixes.
	localparam logic [2:0] CLS_HIGH = 3'b000;
	localparam logic [2:0] CLS_END  = 3'b001;
	localparam logic [1:0] CLS_PAIR = 2'b01;

	typedef struct packed {
		logic [1:0]         range_status;
		logic [SampleW-1:0] sample;
		logic               is_sample;
		logic               end_of_stream;
		logic               last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} pair_t;

	function automatic logic [1:0] range_of(input logic [SampleW-1:0] s);
		logic signed [SampleW-1:0] v;
		v = $signed(s);
		if (v < RangeLow)
			range_of = RANGE_BELOW;
		else if (v > RangeHigh)
			range_of = RANGE_ABOVE;
		else
			range_of = RANGE_IN;
	endfunction

	function automatic res_t make_sample(input logic [SampleW-1:0] s, input logic last);
		res_t r;
		r.range_status  = range_of(s);
		r.sample        = s;
		r.is_sample     = 1'b1;
		r.end_of_stream = 1'b0;
		r.last_of_run   = last;
		make_sample = r;
	endfunction

endpackage

// ----- rtl/dssd_decode.sv -----
// Byte decoder with the running sample state; produces up to two results per byte.
module dssd_decode
	import dssd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] code_byte,
	output pair_t      pair
);

	logic [SampleW-1:0] prev_q;
	logic               pend_q;
	logic [HighW-1:0]   hbits_q;

	logic [SampleW-1:0] prev_d;
	logic               pend_d;
	logic [HighW-1:0]   hbits_d;
	logic [SampleW-1:0] abs_v;
	logic [SampleW-1:0] d7;
	logic [SampleW-1:0] da;
	logic [SampleW-1:0] db;
	logic [SampleW-1:0] sum0;
	logic [SampleW-1:0] sum1;
	logic [AbsW-1:0]    raw;

	assign raw   = {hbits_q, code_byte};
	assign abs_v = {{(SampleW-AbsW){raw[AbsW-1]}}, raw};
	assign d7    = {{(SampleW-Delta7W){code_byte[6]}}, code_byte[6:0]};
	assign da    = {{(SampleW-Delta3W){code_byte[5]}}, code_byte[5:3]};
	assign db    = {{(SampleW-Delta3W){code_byte[2]}}, code_byte[2:0]};
	assign sum0  = prev_q + (code_byte[7] ? d7 : da);
	assign sum1  = sum0 + db;

	always_comb begin
		pair    = '0;
		prev_d  = prev_q;
		pend_d  = 1'b0;
		hbits_d = '0;
		if (pend_q) begin
			// The byte after a high byte is always the low byte, whatever its class.
			prev_d   = abs_v;
			pair.cnt = 2'd1;
			pair.r0  = make_sample(abs_v, 1'b1);
		end else if (code_byte[7]) begin
			prev_d   = sum0;
			pair.cnt = 2'd1;
			pair.r0  = make_sample(sum0, 1'b1);
		end else if (code_byte[7:6] == CLS_PAIR) begin
			prev_d   = sum1;
			pair.cnt = 2'd2;
			pair.r0  = make_sample(sum0, 1'b0);
			pair.r1  = make_sample(sum1, 1'b1);
		end else if (code_byte[7:5] == CLS_END) begin
			prev_d                 = '0;
			pair.cnt               = 2'd1;
			pair.r0.end_of_stream  = 1'b1;
			pair.r0.last_of_run    = 1'b1;
			pair.r0.range_status   = RANGE_IN;
		end else begin
			pend_d  = 1'b1;
			hbits_d = code_byte[HighW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			pend_q  <= 1'b0;
			hbits_q <= '0;
		end else if (advance) begin
			prev_q  <= prev_d;
			pend_q  <= pend_d;
			hbits_q <= hbits_d;
		end
	end

endmodule

// ----- rtl/dssd_out_buf.sv -----
// Two-entry result buffer that hands decoded results to the output stream one at a time.
module dssd_out_buf
	import dssd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  pair_t pair,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  head
);

	logic [1:0] cnt_q;
	res_t       e0_q;
	res_t       e1_q;
	logic       take;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = e0_q;
	assign take      = out_valid && out_ready;
	// New results may enter once the buffer is empty or its last entry leaves now.
	assign room      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pair.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			e0_q <= pair.r0;
			e1_q <= pair.r1;
		end else if (take) begin
			e0_q <= e1_q;
		end
	end

endmodule

// ----- rtl/delta_sample_stream_decoder_core.sv -----
// Top level of the delta sample stream decoder: input register, decoder and result buffer.
//
// Channel | Direction | Payload
// s_*     | in        | s_tdata[7:0] = code_byte
// m_*     | out       | m_tdata[15:0] = sample, [17:16] = range_status, [23:18] = 0;
//         |           | m_tuser[0] = is_sample, [1] = end_of_stream; m_tlast = last_of_run
//
// A byte is registered, then decoded combinationally and loaded into the result buffer
// when it has room. Bytes that give one result pass at one per cycle while the output
// is not stalled; a pair byte holds the result buffer until both of its results have left.
// A high byte gives no result and leaves the buffer empty. Reset clears the running
// sample and all valid flags. A stalled output holds the byte in the input register.
module delta_sample_stream_decoder_core
	import dssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] sample, [17:16] range_status, [23:18] zero
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [0] is_sample, [1] end_of_stream
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       room;
	logic       advance;
	pair_t      pair;
	res_t       head;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dssd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.code_byte (byte_s1),
		.pair      (pair)
	);

	dssd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head)
	);

	assign m_tdata = {6'd0, head.range_status, head.sample};
	assign m_tlast = head.last_of_run;
	assign m_tuser = {head.end_of_stream, head.is_sample};

endmodule

// ----- rtl/dssd_checker.sv -----
// Port-level checker of the delta sample stream decoder and its bind to the top level.
module dssd_checker
	import dssd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// A waiting request keeps its code byte until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("waiting request changed");

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	// The first result of a pair request is always followed by the second.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0])
		else $error("pair result missing its second sample");

	// The end marker carries no sample and closes its run.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 24'd0))
		else $error("malformed end marker");

	// Range status matches the sample value.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			((m_tdata[17:16] == RANGE_ABOVE) == ($signed(m_tdata[15:0]) > RangeHigh))
			&& ((m_tdata[17:16] == RANGE_BELOW) == ($signed(m_tdata[15:0]) < RangeLow))
			&& (m_tdata[23:18] == 6'd0))
		else $error("range status does not match sample");

endmodule

bind delta_sample_stream_decoder_core dssd_checker u_dssd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ----- tb/sv/decoded_sample_checker.sv -----
// Checker that rebuilds the expected decoder results from accepted code bytes and compares them.
`timescale 1ns / 100ps
module decoded_sample_checker
	import dssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [15:0] sample, [17:16] range_status, [23:18] zero
	input  logic        m_tlast,
	input  logic [1:0]  m_tuser,   // [0] is_sample, [1] end_of_stream
	output int          mismatch_count,
	output int          pending_results
);

	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic [1:0]         range_status;
		logic               is_sample;
		logic               end_of_stream;
		logic               last_of_run;
	} decoded_result_t;

	decoded_result_t    expected_results[$];
	logic [SampleW-1:0] running_sample;
	logic               abs_high_waiting;
	logic [HighW-1:0]   abs_high_bits;

	function automatic logic [1:0] classify_range(input logic [SampleW-1:0] value);
		if ($signed(value) < RangeLow)
			return RANGE_BELOW;
		else if ($signed(value) > RangeHigh)
			return RANGE_ABOVE;
		return RANGE_IN;
	endfunction

	task automatic push_sample(input logic [SampleW-1:0] value, input logic last);
		decoded_result_t r;
		r.sample        = value;
		r.range_status  = classify_range(value);
		r.is_sample     = 1'b1;
		r.end_of_stream = 1'b0;
		r.last_of_run   = last;
		expected_results.push_back(r);
	endtask

	task automatic decode_code_byte(input logic [7:0] code);
		decoded_result_t marker;
		if (abs_high_waiting) begin
			// Whatever its class, this byte completes the 13-bit absolute value.
			running_sample   = {{(SampleW-AbsW){abs_high_bits[HighW-1]}}, abs_high_bits, code};
			abs_high_waiting = 1'b0;
			abs_high_bits    = '0;
			push_sample(running_sample, 1'b1);
		end else if (code[7]) begin
			running_sample = running_sample + {{(SampleW-Delta7W){code[6]}}, code[6:0]};
			push_sample(running_sample, 1'b1);
		end else if (code[7:6] == CLS_PAIR) begin
			running_sample = running_sample + {{(SampleW-Delta3W){code[5]}}, code[5:3]};
			push_sample(running_sample, 1'b0);
			running_sample = running_sample + {{(SampleW-Delta3W){code[2]}}, code[2:0]};
			push_sample(running_sample, 1'b1);
		end else if (code[7:5] == CLS_END) begin
			running_sample         = '0;
			marker                 = '0;
			marker.range_status    = RANGE_IN;
			marker.end_of_stream   = 1'b1;
			marker.last_of_run     = 1'b1;
			expected_results.push_back(marker);
		end else begin
			// High byte: it only waits for its low byte.
			abs_high_waiting = 1'b1;
			abs_high_bits    = code[HighW-1:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_result_t seen;
		decoded_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			running_sample   = '0;
			abs_high_waiting = 1'b0;
			abs_high_bits    = '0;
			mismatch_count   = 0;
		end else begin
			// A result can never stem from a request accepted at the same edge,
			// so results are compared before the new request is decoded.
			if (m_tvalid && m_tready) begin
				seen.sample        = m_tdata[15:0];
				seen.range_status  = m_tdata[17:16];
				seen.is_sample     = m_tuser[0];
				seen.end_of_stream = m_tuser[1];
				seen.last_of_run   = m_tlast;
				if (expected_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: sample %0d range %0d flags %b%b%b",
							$signed(seen.sample), seen.range_status, seen.is_sample,
							seen.end_of_stream, seen.last_of_run);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (seen.sample !== want.sample || seen.range_status !== want.range_status ||
						seen.is_sample !== want.is_sample ||
						seen.end_of_stream !== want.end_of_stream ||
						seen.last_of_run !== want.last_of_run || m_tdata[23:18] !== '0) begin
						if (mismatch_count < 10)
							$display({"mismatch (expected/actual): sample %0d/%0d range %0d/%0d ",
								"is_sample %b/%b end %b/%b last %b/%b pad 0/%h"},
								$signed(want.sample), $signed(seen.sample),
								want.range_status, seen.range_status,
								want.is_sample, seen.is_sample,
								want.end_of_stream, seen.end_of_stream,
								want.last_of_run, seen.last_of_run, m_tdata[23:18]);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_code_byte(s_tdata);
		end
		pending_results = expected_results.size();
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the decoder testbench: clock, reset, byte stimulus, result sink and verdict.
`timescale 1ns / 100ps
module testbench
	import dssd_pkg::*;
();

	localparam int   CodeCount   = 1850;
	localparam int   RampLength  = 540;
	localparam int   IdleLimit   = 200;
	localparam int   DrainCycles = 20;
	localparam logic DeltaTag    = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	int   mismatch_count;
	int   pending_results;
	int   sent_codes    = 0;
	int   idle_cycles   = 0;
	int   src_run_left  = 0;
	int   sink_run_left = 0;
	logic src_steady    = 1'b0;
	logic sink_steady   = 1'b0;

	always #10 clk = ~clk;

	delta_sample_stream_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	decoded_sample_checker sample_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// Sends one code byte as a request, after a random gap unless in a steady stretch.
	task automatic send_code(input logic [7:0] code);
		int gap;
		if (src_run_left == 0) begin
			src_steady   = ($urandom_range(0, 3) == 0);
			src_run_left = $urandom_range(16, 96);
		end
		src_run_left--;
		gap = src_steady ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
		sent_codes++;
	endtask

	// Starts from a clean state at an absolute extreme and drives large deltas of one sign
	// until the running sample wraps around.
	task automatic send_ramp(input logic rising);
		send_code({CLS_END, 5'($urandom)});
		if (rising) begin
			send_code({CLS_HIGH, 5'h0F});
			send_code(8'hFF);
		end else begin
			send_code({CLS_HIGH, 5'h10});
			send_code(8'h00);
		end
		repeat (RampLength)
			send_code(rising ? {DeltaTag, 4'b0111, 3'($urandom)} :
				{DeltaTag, 4'b1000, 3'($urandom)});
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_run_left == 0) begin
				sink_steady   = ($urandom_range(0, 3) == 0);
				sink_run_left = $urandom_range(16, 96);
			end
			sink_run_left--;
			stall = sink_steady ? 0 : $urandom_range(0, 5);
			repeat (stall) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int   pick;
		logic ramp_up_done;
		logic ramp_down_done;
		ramp_up_done   = 1'b0;
		ramp_down_done = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Delta extremes, starting from the cleared sample.
		send_code({DeltaTag, 7'h00});
		send_code({DeltaTag, 7'h3F});
		send_code({DeltaTag, 7'h40});
		send_code({DeltaTag, 7'h7F});
		// Pair bytes with zero, negative and extreme deltas.
		send_code({CLS_PAIR, 6'o00});
		send_code({CLS_PAIR, 6'o77});
		send_code({CLS_PAIR, 6'o34});
		send_code({CLS_PAIR, 6'o43});
		// Absolute values at the 13-bit extremes.
		send_code({CLS_HIGH, 5'h0F});
		send_code(8'hFF);
		send_code({CLS_HIGH, 5'h10});
		send_code(8'h00);
		// Range edges, with low bytes of delta and end class.
		send_code({CLS_HIGH, 5'h07});
		send_code(8'hD0);
		send_code({DeltaTag, 7'h01});
		send_code({CLS_HIGH, 5'h18});
		send_code(8'h30);
		send_code({DeltaTag, 7'h7F});
		// A high byte taken as the low byte of another one.
		send_code({CLS_HIGH, 5'h00});
		send_code({CLS_HIGH, 5'h1F});
		// End marker, then a delta from the cleared sample.
		send_code({CLS_END, 5'h1F});
		send_code({DeltaTag, 7'h05});

		while (sent_codes < CodeCount) begin
			if (!ramp_up_done && sent_codes > 300) begin
				send_ramp(1'b1);
				ramp_up_done = 1'b1;
			end else if (!ramp_down_done && sent_codes > 1000) begin
				send_ramp(1'b0);
				ramp_down_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 35)
				repeat ($urandom_range(1, 8)) send_code({DeltaTag, 7'($urandom)});
			else if (pick < 55)
				repeat ($urandom_range(1, 6)) send_code({CLS_PAIR, 6'($urandom)});
			else if (pick < 80) begin
				send_code({CLS_HIGH, 5'($urandom)});
				send_code(8'($urandom));
			end else if (pick < 88)
				send_code({CLS_END, 5'($urandom)});
			else
				send_code(8'($urandom));
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending_results != 0);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
